FILE: src/rdsr_pkg.sv
// ----------------------------------------------------------------------------
// rdsr_pkg: shared types and constants of the stereogram row generator
// Holds the controller states, the command and status groups between the
// controller and the datapath, the configuration record and register map.
// ----------------------------------------------------------------------------
package rdsr_pkg;

    // Width of the shared iterative divider.
    localparam int DIVW = 16;

    // Register byte addresses on the configuration port.
    localparam logic [4:0] ADDR_MAX_COLORS  = 5'd0;
    localparam logic [4:0] ADDR_EXCLUSIVE   = 5'd4;
    localparam logic [4:0] ADDR_MAX_OFFSET  = 5'd8;
    localparam logic [4:0] ADDR_CONCAVE     = 5'd12;
    localparam logic [4:0] ADDR_ROW_WIDTH   = 5'd16;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Load divisions in order: depth divisor, background, foreground, disparity.
    localparam logic [1:0] PH_DIVISOR = 2'd0;
    localparam logic [1:0] PH_BG      = 2'd1;
    localparam logic [1:0] PH_FG      = 2'd2;
    localparam logic [1:0] PH_DISP    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LSTART,
        S_LWAIT,
        S_LWRITE,
        S_CRD,
        S_CWR,
        S_PRD,
        S_PEV,
        S_PWAIT,
        S_PFRD,
        S_PFWR,
        S_ORD,
        S_OEMIT
    } t_state;

    typedef struct packed {
        logic [8:0]  max_colors;
        logic [7:0]  exclusive_colors;
        logic [7:0]  max_offset;
        logic        concave_mode;
        logic [10:0] row_width;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_wrap;
        logic ph_store;
        logic ld_write;
        logic restart;
        logic cnt_clr;
        logic cnt_inc;
        logic copy_wr;
        logic ev_wr;
        logic wrap_rd;
        logic wrap_wr;
        logic set_computed;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic load_full;
        logic load_short;
        logic drain_end;
        logic computed;
        logic div_done;
        logic ph_last;
        logic cnt_last;
        logic disp_zero;
        logic concave;
        logic out_free;
    } t_stat;

endpackage

FILE: src/rdsr_div.sv
// ----------------------------------------------------------------------------
// rdsr_div: iterative restoring divider
// Produces one quotient bit per cycle; quotient and remainder stay valid
// from the done pulse until the next start.
// ----------------------------------------------------------------------------
module rdsr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rdsr_pkg::DIVW-1:0] i_dividend,
    input  logic [rdsr_pkg::DIVW-1:0] i_divisor,
    output logic [rdsr_pkg::DIVW-1:0] o_quo,
    output logic [rdsr_pkg::DIVW-1:0] o_rem,
    output logic                      o_busy,
    output logic                      o_done
);

    localparam int W  = rdsr_pkg::DIVW;
    localparam int CNW = $clog2(W);

    logic [W-1:0]   r_quo;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_div;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [W:0]     trial;
    logic           ge;
    logic [W-1:0]   n_rem;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? W'(trial - {1'b0, r_div}) : trial[W-1:0];
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

FILE: src/rdsr_ctrl.sv
// ----------------------------------------------------------------------------
// rdsr_ctrl: sequencer of the stereogram row generator
// Walks each accepted word through its load, render or drain steps and
// drives the datapath by command signals.
// ----------------------------------------------------------------------------
module rdsr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rdsr_pkg::t_stat i_stat,
    output rdsr_pkg::t_cmd  o_cmd
);

    rdsr_pkg::t_state r_state;
    rdsr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdsr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdsr_pkg::S_IDLE: begin
                if (i_valid) n_state = rdsr_pkg::S_DISPATCH;
            end
            rdsr_pkg::S_DISPATCH: begin
                if (i_stat.op == rdsr_pkg::OP_LOAD) begin
                    n_state = i_stat.load_full ? rdsr_pkg::S_IDLE : rdsr_pkg::S_LSTART;
                end else if (i_stat.load_short || i_stat.drain_end) begin
                    n_state = rdsr_pkg::S_IDLE;
                end else if (i_stat.computed) begin
                    n_state = rdsr_pkg::S_ORD;
                end else begin
                    n_state = rdsr_pkg::S_CRD;
                end
            end
            rdsr_pkg::S_LSTART: n_state = rdsr_pkg::S_LWAIT;
            rdsr_pkg::S_LWAIT: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.ph_last ? rdsr_pkg::S_LWRITE : rdsr_pkg::S_LSTART;
                end
            end
            rdsr_pkg::S_LWRITE: n_state = rdsr_pkg::S_IDLE;
            rdsr_pkg::S_CRD:    n_state = rdsr_pkg::S_CWR;
            rdsr_pkg::S_CWR: begin
                n_state = i_stat.cnt_last ? rdsr_pkg::S_PRD : rdsr_pkg::S_CRD;
            end
            rdsr_pkg::S_PRD:    n_state = rdsr_pkg::S_PEV;
            rdsr_pkg::S_PEV: begin
                if (i_stat.concave && !i_stat.disp_zero) begin
                    n_state = rdsr_pkg::S_PWAIT;
                end else begin
                    n_state = i_stat.cnt_last ? rdsr_pkg::S_ORD : rdsr_pkg::S_PRD;
                end
            end
            rdsr_pkg::S_PWAIT: begin
                if (i_stat.div_done) n_state = rdsr_pkg::S_PFRD;
            end
            rdsr_pkg::S_PFRD:   n_state = rdsr_pkg::S_PFWR;
            rdsr_pkg::S_PFWR: begin
                n_state = i_stat.cnt_last ? rdsr_pkg::S_ORD : rdsr_pkg::S_PRD;
            end
            rdsr_pkg::S_ORD:    n_state = rdsr_pkg::S_OEMIT;
            rdsr_pkg::S_OEMIT: begin
                if (i_stat.out_free) n_state = rdsr_pkg::S_IDLE;
            end
            default: n_state = rdsr_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            rdsr_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_valid;
            end
            rdsr_pkg::S_DISPATCH: begin
                if (i_stat.op == rdsr_pkg::OP_DRAIN && !i_stat.load_short) begin
                    o_cmd.restart = i_stat.drain_end;
                    o_cmd.cnt_clr = !i_stat.drain_end && !i_stat.computed;
                end
            end
            rdsr_pkg::S_LSTART: o_cmd.div_start = 1'b1;
            rdsr_pkg::S_LWAIT:  o_cmd.ph_store  = i_stat.div_done;
            rdsr_pkg::S_LWRITE: o_cmd.ld_write  = 1'b1;
            rdsr_pkg::S_CWR: begin
                o_cmd.copy_wr = 1'b1;
                o_cmd.cnt_clr = i_stat.cnt_last;
                o_cmd.cnt_inc = !i_stat.cnt_last;
            end
            rdsr_pkg::S_PEV: begin
                o_cmd.ev_wr = 1'b1;
                if (i_stat.concave && !i_stat.disp_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_wrap  = 1'b1;
                end else begin
                    o_cmd.set_computed = i_stat.cnt_last;
                    o_cmd.cnt_inc      = !i_stat.cnt_last;
                end
            end
            rdsr_pkg::S_PFRD: o_cmd.wrap_rd = 1'b1;
            rdsr_pkg::S_PFWR: begin
                o_cmd.wrap_wr      = 1'b1;
                o_cmd.set_computed = i_stat.cnt_last;
                o_cmd.cnt_inc      = !i_stat.cnt_last;
            end
            rdsr_pkg::S_OEMIT: o_cmd.emit = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: src/rdsr_dp.sv
// ----------------------------------------------------------------------------
// rdsr_dp: datapath of the stereogram row generator
// Holds the five row memories, the pointers, the load arithmetic through a
// shared divider, the render addressing and the output register.
// ----------------------------------------------------------------------------
module rdsr_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rdsr_pkg::t_cfg  i_cfg,
    input  rdsr_pkg::t_cmd  i_cmd,
    output rdsr_pkg::t_stat o_stat,
    input  logic            i_op,
    input  logic [37:0]     i_data,
    input  logic            i_m_tready,
    output logic            o_m_tvalid,
    output logic [15:0]     o_m_tdata,
    output logic            o_m_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int W  = rdsr_pkg::DIVW;

    // Row memories.
    logic [7:0] bg_mem    [MAX_WIDTH];
    logic [7:0] fg_mem    [MAX_WIDTH];
    logic [7:0] disp_mem  [MAX_WIDTH];
    logic [7:0] left_mem  [MAX_WIDTH];
    logic [7:0] right_mem [MAX_WIDTH];
    logic [7:0] bg_q, fg_q, disp_q, left_q, right_q;

    // Captured word and load results.
    logic        r_op;
    logic [7:0]  r_gray;
    logic [14:0] r_rb;
    logic [14:0] r_rf;
    logic [7:0]  r_d;
    logic [7:0]  r_bgc;
    logic [7:0]  r_fgc;
    logic [7:0]  r_disp;
    logic [1:0]  r_ph;

    // Row control state.
    logic [CW-1:0] r_lp, n_lp;
    logic [CW-1:0] r_dp, n_dp;
    logic          r_computed, n_computed;
    logic [AW-1:0] r_i;

    // Output register.
    logic        r_ovalid;
    logic [7:0]  r_oleft;
    logic [7:0]  r_oright;
    logic        r_olast;

    // Divider signals.
    logic [W-1:0] div_a, div_b, div_quo, div_rem;
    logic         div_busy, div_done;

    logic [CW-1:0] w;
    logic [8:0]    m;
    logic [7:0]    offs;
    logic [W-1:0]  i_w, l_sum, r_sub;
    logic [6:0]    ol;
    logic [7:0]    orr;
    logic          l_en, r_en, last;
    logic          left_we, right_we;
    logic [AW-1:0] left_wa, right_wa, fg_ra;
    logic [7:0]    left_wd, right_wd;

    // Effective width, palette modulus and depth divisor.
    always_comb begin
        if (i_cfg.row_width == '0) begin
            w = CW'(1);
        end else if (32'(i_cfg.row_width) > MAX_WIDTH) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(i_cfg.row_width);
        end
        m    = (i_cfg.max_colors > {1'b0, i_cfg.exclusive_colors}) ?
               i_cfg.max_colors - {1'b0, i_cfg.exclusive_colors} : 9'd1;
        offs = (i_cfg.max_offset == '0) ? 8'd1 : i_cfg.max_offset;
    end

    // Divider operands: the four load divisions and the concave wrap.
    always_comb begin
        if (i_cmd.div_wrap) begin
            div_a = W'(r_i) + W'(disp_q);
            div_b = W'(w);
        end else begin
            case (r_ph)
                rdsr_pkg::PH_DIVISOR: begin
                    div_a = W'(255);
                    div_b = W'(offs);
                end
                rdsr_pkg::PH_BG: begin
                    div_a = W'(r_rb);
                    div_b = W'(m);
                end
                rdsr_pkg::PH_FG: begin
                    div_a = W'(r_rf);
                    div_b = W'(m);
                end
                default: begin
                    div_a = W'({r_gray, 1'b0}) + W'(r_d);
                    div_b = W'({r_d, 1'b0});
                end
            endcase
        end
    end

    rdsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    // Capture of the accepted word and of the load results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_gray <= i_data[7:0];
            r_rb   <= i_data[22:8];
            r_rf   <= i_data[37:23];
        end
        if (i_cmd.ph_store) begin
            case (r_ph)
                rdsr_pkg::PH_DIVISOR: r_d    <= div_quo[7:0];
                rdsr_pkg::PH_BG:      r_bgc  <= div_rem[7:0];
                rdsr_pkg::PH_FG:      r_fgc  <= div_rem[7:0] + i_cfg.exclusive_colors;
                default:              r_disp <= div_quo[7:0];
            endcase
        end
    end

    // Load phase counter and pixel counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= rdsr_pkg::PH_DIVISOR;
            r_i  <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_ph <= rdsr_pkg::PH_DIVISOR;
            end else if (i_cmd.ph_store) begin
                r_ph <= r_ph + 2'd1;
            end
            if (i_cmd.cnt_clr) begin
                r_i <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    // Pointers and the rendered flag.
    assign last = (W'(r_dp) == W'(w) - W'(1));

    always_comb begin
        n_lp       = r_lp;
        n_dp       = r_dp;
        n_computed = r_computed;
        if (i_cmd.ld_write) n_lp = r_lp + 1'b1;
        if (i_cmd.set_computed) n_computed = 1'b1;
        if (i_cmd.emit) n_dp = r_dp + 1'b1;
        if (i_cmd.restart || (i_cmd.emit && last)) begin
            n_lp       = '0;
            n_dp       = '0;
            n_computed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp       <= '0;
            r_dp       <= '0;
            r_computed <= 1'b0;
        end else begin
            r_lp       <= n_lp;
            r_dp       <= n_dp;
            r_computed <= n_computed;
        end
    end

    // Render addressing: convex scatter targets and concave writes.
    always_comb begin
        i_w   = W'(r_i);
        ol    = disp_q[7:1];
        orr   = disp_q - {1'b0, ol};
        l_sum = i_w + W'(ol);
        r_sub = i_w - W'(orr);
        l_en  = (disp_q != '0) && !i_cfg.concave_mode && (l_sum < W'(w));
        r_en  = (disp_q != '0) && (i_cfg.concave_mode || (i_w >= W'(orr)));

        left_we  = i_cmd.copy_wr || (i_cmd.ev_wr && l_en) || i_cmd.wrap_wr;
        left_wa  = (i_cmd.ev_wr && !i_cmd.wrap_wr) ? l_sum[AW-1:0] : r_i;
        left_wd  = i_cmd.copy_wr ? bg_q : fg_q;
        right_we = i_cmd.copy_wr || (i_cmd.ev_wr && r_en);
        right_wa = (i_cmd.ev_wr && !i_cfg.concave_mode) ? r_sub[AW-1:0] : r_i;
        right_wd = i_cmd.copy_wr ? bg_q : fg_q;
        fg_ra    = i_cmd.wrap_rd ? div_rem[AW-1:0] : r_i;
    end

    // Source rows: written by loads, read by the render passes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_write) begin
            bg_mem[r_lp[AW-1:0]]   <= r_bgc;
            fg_mem[r_lp[AW-1:0]]   <= r_fgc;
            disp_mem[r_lp[AW-1:0]] <= r_disp;
        end
        bg_q   <= bg_mem[r_i];
        fg_q   <= fg_mem[fg_ra];
        disp_q <= disp_mem[r_i];
    end

    // Rendered rows: written by the render passes, read by drains.
    always_ff @(posedge i_clk) begin
        if (left_we) left_mem[left_wa] <= left_wd;
        if (right_we) right_mem[right_wa] <= right_wd;
        left_q  <= left_mem[r_dp[AW-1:0]];
        right_q <= right_mem[r_dp[AW-1:0]];
    end

    // Output register: loaded by a drain, cleared when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_oleft  <= left_q;
            r_oright <= right_q;
            r_olast  <= last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_oright, r_oleft};
    assign o_m_tlast  = r_olast;

    // Status to the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.load_full  = (r_lp >= w);
        o_stat.load_short = (r_lp < w) && !r_computed;
        o_stat.drain_end  = (r_dp >= w);
        o_stat.computed   = r_computed;
        o_stat.div_done   = div_done;
        o_stat.ph_last    = (r_ph == rdsr_pkg::PH_DISP);
        o_stat.cnt_last   = (i_w == W'(w) - W'(1));
        o_stat.disp_zero  = (disp_q == '0);
        o_stat.concave    = i_cfg.concave_mode;
        o_stat.out_free   = !r_ovalid || i_m_tready;
    end

    // The divider is never restarted while it iterates.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    // A result is never written over one that waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || i_m_tready))
        else $error("output word overwritten");

    // A completed division follows an active iteration.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> $past(div_busy))
        else $error("divider done without iteration");

endmodule

FILE: src/random_dot_stereogram_row.sv
// ----------------------------------------------------------------------------
// random_dot_stereogram_row: one-row random-dot stereogram generator
// Top level with the configuration registers, the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage: words arrive on the s_ stream. tuser 0 loads the next pixel of the
// row (gray, two random words); tuser 1 drains the next output pixel pair.
// Loads give no output word. Drains before the row is fully loaded give none.
// The first drain of a complete row renders the left and right rows first.
// One word is taken at a time; s_tready is high only while the sequencer waits.
// A load runs four passes of the shared divider. The first drain of a row
// adds the render, with one more division per shifted pixel in concave
// mode by the shared divider, which folds the gather index into the row.
// The output word sits in a register: a stalled m_tready holds it while the
// next input word is taken; only the next drain waits for that slot.
// Reset clears the pointers and the rendered flag and loads the register
// defaults; the row memories come up undefined and need no clearing pass.
// The user writes registers over the APB-style port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module random_dot_stereogram_row #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. tdata: depth_gray[7:0], rand_bg[22:8], rand_fg[37:23]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // tuser: op
    input  logic        s_tuser,
    // Output stream. tdata: left_color[7:0], right_color[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // tlast: row_last
    output logic        m_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rdsr_pkg::t_cfg  r_cfg;
    rdsr_pkg::t_cmd  cmd;
    rdsr_pkg::t_stat stat;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_colors       <= 9'd4;
            r_cfg.exclusive_colors <= 8'd0;
            r_cfg.max_offset       <= 8'd6;
            r_cfg.concave_mode     <= 1'b0;
            r_cfg.row_width        <= 11'd1024;
        end else if (wr_en) begin
            unique case (paddr)
                rdsr_pkg::ADDR_MAX_COLORS: r_cfg.max_colors       <= pwdata[8:0];
                rdsr_pkg::ADDR_EXCLUSIVE:  r_cfg.exclusive_colors <= pwdata[7:0];
                rdsr_pkg::ADDR_MAX_OFFSET: r_cfg.max_offset       <= pwdata[7:0];
                rdsr_pkg::ADDR_CONCAVE:    r_cfg.concave_mode     <= pwdata[0];
                rdsr_pkg::ADDR_ROW_WIDTH:  r_cfg.row_width        <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr)
            rdsr_pkg::ADDR_MAX_COLORS: prdata = 32'(r_cfg.max_colors);
            rdsr_pkg::ADDR_EXCLUSIVE:  prdata = 32'(r_cfg.exclusive_colors);
            rdsr_pkg::ADDR_MAX_OFFSET: prdata = 32'(r_cfg.max_offset);
            rdsr_pkg::ADDR_CONCAVE:    prdata = 32'(r_cfg.concave_mode);
            rdsr_pkg::ADDR_ROW_WIDTH:  prdata = 32'(r_cfg.row_width);
            default:                   prdata = '0;
        endcase
    end

    rdsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rdsr_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_op       (s_tuser),
        .i_data     (s_tdata[37:0]),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule

FILE: test/tb_random_dot_stereogram_row.sv
// ----------------------------------------------------------------------------
// tb_random_dot_stereogram_row: self-checking bench for the stereogram row
// Rows of load words are streamed in and drained back out. A predictor
// tracks the row memories and renders the left and right rows in convex or
// concave mode. Each output word is checked against the oldest prediction.
// Registers change only while the block is idle, at times in the middle of a row.
// ----------------------------------------------------------------------------
module tb_random_dot_stereogram_row;

    localparam int ROW_MAX = 1024;
    localparam int SETTLE  = 200;

    typedef struct {
        logic        op;
        logic [7:0]  gray;
        logic [14:0] rnd_bg;
        logic [14:0] rnd_fg;
    } t_pix_word;

    typedef struct {
        logic [7:0] left;
        logic [7:0] right;
        logic       last;
    } t_out_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    random_dot_stereogram_row u_dut (.*);

    // Predictor copy of the registers and the row state.
    int unsigned cfg_colors, cfg_excl, cfg_offset, cfg_concave, cfg_width;
    logic [7:0]  bg_row [ROW_MAX];
    logic [7:0]  fg_row [ROW_MAX];
    logic [7:0]  disp_row [ROW_MAX];
    logic [7:0]  left_row [ROW_MAX];
    logic [7:0]  right_row [ROW_MAX];
    int unsigned load_ptr, drain_ptr;
    bit          rendered;

    t_pix_word   pend_q[$];
    t_out_word   pixel_q[$];
    t_pix_word   cur;
    int          errors;
    int          issued;
    int          in_gap, out_gap;
    bit          calm;
    bit          hold_req, hold_done;
    int          hold_left;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #16000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic int unsigned row_span();
        if (cfg_width == 0) return 1;
        if (cfg_width > ROW_MAX) return ROW_MAX;
        return cfg_width;
    endfunction

    // Render both rows from the stored background, foreground and disparity.
    task automatic render_rows(input int unsigned w);
        int unsigned o, half_l, half_r;
        for (int unsigned i = 0; i < w; i++) begin
            left_row[i]  = bg_row[i];
            right_row[i] = bg_row[i];
        end
        for (int unsigned i = 0; i < w; i++) begin
            o = disp_row[i];
            if (o != 0) begin
                if (cfg_concave != 0) begin
                    left_row[i]  = fg_row[(i + o) % w];
                    right_row[i] = fg_row[i];
                end else begin
                    half_l = o >> 1;
                    half_r = o - half_l;
                    if (i + half_l < w) left_row[i + half_l] = fg_row[i];
                    if (i >= half_r) right_row[i - half_r] = fg_row[i];
                end
            end
        end
    endtask

    // Advance the row state by one accepted word and queue any output pixel.
    task automatic stereo_step(input t_pix_word it);
        int unsigned w, m, div;
        t_out_word   px;
        w = row_span();
        if (it.op == rdsr_pkg::OP_LOAD) begin
            if (load_ptr >= w) return;
            m   = (cfg_colors > cfg_excl) ? cfg_colors - cfg_excl : 1;
            div = 255 / ((cfg_offset != 0) ? cfg_offset : 1);
            bg_row[load_ptr]   = 8'(it.rnd_bg % m);
            fg_row[load_ptr]   = 8'(it.rnd_fg % m + cfg_excl);
            disp_row[load_ptr] = 8'((2 * it.gray + div) / (2 * div));
            load_ptr++;
            return;
        end
        if (load_ptr < w && !rendered) return;
        if (drain_ptr >= w) begin
            load_ptr = 0; drain_ptr = 0; rendered = 0;
            return;
        end
        if (!rendered) begin
            render_rows(w);
            rendered = 1;
        end
        px.left  = left_row[drain_ptr];
        px.right = right_row[drain_ptr];
        px.last  = (drain_ptr == w - 1);
        pixel_q.push_back(px);
        drain_ptr++;
        if (px.last) begin
            load_ptr = 0; drain_ptr = 0; rendered = 0;
        end
    endtask

    // Input driver: takes words from the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) stereo_step(cur);
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap   <= in_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    in_gap   <= $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur.op;
                    s_tdata  <= {2'b00, cur.rnd_fg, cur.rnd_bg, cur.gray};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, requested once by the stimulus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output side: random stall bursts and the check against predictions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            out_gap  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    report("unexpected word", m_tdata, 0);
                end else begin
                    t_out_word px;
                    px = pixel_q.pop_front();
                    if (m_tdata[7:0] !== px.left) report("left_color", m_tdata[7:0], px.left);
                    if (m_tdata[15:8] !== px.right)
                        report("right_color", m_tdata[15:8], px.right);
                    if (m_tlast !== px.last) report("row_last", m_tlast, px.last);
                end
            end
            if (hold_left > 0 || (hold_req && !hold_done)) begin
                m_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap  <= out_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                out_gap  <= $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(input logic [4:0] addr, input int unsigned val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (addr)
            rdsr_pkg::ADDR_MAX_COLORS: cfg_colors  = val & 32'h1FF;
            rdsr_pkg::ADDR_EXCLUSIVE:  cfg_excl    = val & 32'hFF;
            rdsr_pkg::ADDR_MAX_OFFSET: cfg_offset  = val & 32'hFF;
            rdsr_pkg::ADDR_CONCAVE:    cfg_concave = val & 32'h1;
            rdsr_pkg::ADDR_ROW_WIDTH:  cfg_width   = val & 32'h7FF;
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned colors, input int unsigned excl,
                              input int unsigned offs, input int unsigned cave,
                              input int unsigned w);
        reg_write(rdsr_pkg::ADDR_MAX_COLORS, colors);
        reg_write(rdsr_pkg::ADDR_EXCLUSIVE, excl);
        reg_write(rdsr_pkg::ADDR_MAX_OFFSET, offs);
        reg_write(rdsr_pkg::ADDR_CONCAVE, cave);
        reg_write(rdsr_pkg::ADDR_ROW_WIDTH, w);
    endtask

    // Wait until every word is sent and every pixel has come back.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pend_q.size() > 0 || s_tvalid || pixel_q.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_word(input logic op, input logic [7:0] g,
                             input logic [14:0] rb, input logic [14:0] rf);
        t_pix_word it;
        it.op = op; it.gray = g; it.rnd_bg = rb; it.rnd_fg = rf;
        pend_q.push_back(it);
        issued++;
    endtask

    task automatic push_random(input logic op);
        logic [7:0] g;
        case ($urandom_range(0, 7))
            0: g = 8'd0;
            1: g = 8'd255;
            default: g = 8'($urandom);
        endcase
        push_word(op, g, 15'($urandom), 15'($urandom));
    endtask

    // One full row: loads, then drains, with optional early drain and extra load.
    task automatic run_row(input int unsigned npix, input bit noise);
        if (noise) push_random(rdsr_pkg::OP_DRAIN);
        for (int unsigned i = 0; i < npix; i++) push_random(rdsr_pkg::OP_LOAD);
        if (noise) push_random(rdsr_pkg::OP_LOAD);
        for (int unsigned i = 0; i < npix; i++) push_random(rdsr_pkg::OP_DRAIN);
        wait_idle();
    endtask

    // Stimulus.
    initial begin
        int unsigned w;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_colors = 4; cfg_excl = 0; cfg_offset = 6; cfg_concave = 0; cfg_width = 1024;
        load_ptr = 0; drain_ptr = 0; rendered = 0;
        errors = 0; issued = 0; calm = 0; hold_req = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Field extremes at the default palette, a narrow convex row.
        reg_write(rdsr_pkg::ADDR_ROW_WIDTH, 4);
        push_word(rdsr_pkg::OP_DRAIN, 8'd0, 15'd0, 15'd0);
        push_word(rdsr_pkg::OP_LOAD, 8'd0, 15'd0, 15'd0);
        push_word(rdsr_pkg::OP_LOAD, 8'd255, 15'h7FFF, 15'h7FFF);
        push_word(rdsr_pkg::OP_LOAD, 8'd128, 15'h5555, 15'h2AAA);
        push_word(rdsr_pkg::OP_LOAD, 8'd255, 15'h2AAA, 15'h5555);
        push_word(rdsr_pkg::OP_LOAD, 8'd77, 15'h1234, 15'h4321);
        repeat (4) push_word(rdsr_pkg::OP_DRAIN, 8'hFF, 15'h7FFF, 15'h7FFF);
        push_word(rdsr_pkg::OP_DRAIN, 8'd0, 15'd0, 15'd0);
        wait_idle();

        // Zero width and zero offset, empty palette, concave.
        set_config(2, 255, 0, 1, 0);
        run_row(1, 1);
        // Wide palette with colors past 255, largest offset, concave.
        set_config(511, 200, 255, 1, 5);
        run_row(5, 0);

        // Width shrunk under the drain pointer.
        set_config(16, 3, 8, 0, 6);
        for (int i = 0; i < 6; i++) push_random(rdsr_pkg::OP_LOAD);
        for (int i = 0; i < 4; i++) push_random(rdsr_pkg::OP_DRAIN);
        wait_idle();
        reg_write(rdsr_pkg::ADDR_ROW_WIDTH, 2);
        push_random(rdsr_pkg::OP_DRAIN);
        wait_idle();

        // Width above the row memory: a partial row still counts as short,
        // then the width shrinks below the loaded pixels and the row drains.
        set_config(256, 0, 1, 0, 2047);
        for (int i = 0; i < 150; i++) push_random(rdsr_pkg::OP_LOAD);
        push_random(rdsr_pkg::OP_DRAIN);
        wait_idle();
        reg_write(rdsr_pkg::ADDR_ROW_WIDTH, 100);
        for (int i = 0; i < 100; i++) push_random(rdsr_pkg::OP_DRAIN);
        wait_idle();

        // Random rows; one of them meets a long receiver hold-off.
        while (issued < 600) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            set_config($urandom_range(0, 511), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 1), w);
            if (issued > 520) calm = 1;
            if (!hold_req && issued > 420) begin
                for (int unsigned i = 0; i < w; i++) push_random(rdsr_pkg::OP_LOAD);
                wait_idle();
                hold_req = 1;
                for (int unsigned i = 0; i < w; i++) push_random(rdsr_pkg::OP_DRAIN);
                wait_idle();
            end else begin
                run_row(w, $urandom_range(0, 3) == 0);
            end
        end

        wait_idle();
        if (errors == 0 && pixel_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
